// ===== rtl/gif_lzw_encoder_top_macros.svh =====
// Assertion macros used by the encoder's top level
`ifndef GIF_LZW_ENCODER_TOP_MACROS_SVH
`define GIF_LZW_ENCODER_TOP_MACROS_SVH

// condition must hold at every clock edge out of reset
`define GLE_ASSERT_ALWAYS(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define GLE_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/gle_pkg.sv =====
// Types and constants of the GIF LZW encoder
`default_nettype none
package gle_pkg;

	localparam int TABLE_ENTRIES = 4097;
	localparam int ADDR_W = 13;
	localparam int SYM_W = 8;
	localparam logic [ADDR_W-1:0] NO_ENTRY = 13'h1FFF;
	localparam logic [ADDR_W-1:0] ENTRY_LIMIT = 13'd4097;
	localparam logic [ADDR_W-1:0] LAST_ENTRY = 13'd4096;
	localparam logic [3:0] MAX_CODE_WIDTH = 4'd12;
	localparam logic [3:0] CFG_RESET = 4'd8;

	typedef struct packed {
		logic [7:0] pixel_index;
		logic       last_pixel;
	} pix_in_t;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       sub_block_end;
		logic       stream_end;
	} byte_out_t;

	// one classified pixel between front and back
	typedef struct packed {
		logic [7:0] pix;
		logic       last;
		logic       first;
		logic [3:0] bits;
	} work_t;

	// one code request to the packer
	typedef struct packed {
		logic [ADDR_W-1:0] code;
		logic [3:0]        width;
		logic              final_code;
	} code_req_t;

endpackage
`default_nettype wire

// ===== rtl/gle_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module gle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4097
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/gle_front.sv =====
// Front end: configuration register, image start detection, pixel masking
`default_nettype none
module gle_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [3:0]      cfg_wdata,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire gle_pkg::pix_in_t in_data,
	output logic                 push_valid,
	input  wire logic            push_ready,
	output gle_pkg::work_t       push_data
);
	import gle_pkg::*;

	logic [3:0] cfg_q;
	logic [3:0] bits_q;
	logic       started_q;
	logic [3:0] cfg_bits;
	logic [3:0] use_bits;
	logic [7:0] mask;
	logic       accept;

	// out-of-range sizes clamp to 1..8
	always_comb begin
		if (cfg_q < 4'd1) begin
			cfg_bits = 4'd1;
		end else if (cfg_q > 4'd8) begin
			cfg_bits = 4'd8;
		end else begin
			cfg_bits = cfg_q;
		end
		use_bits = started_q ? bits_q : cfg_bits;
		mask = 8'((9'd1 << use_bits) - 9'd1);
	end

	assign in_ready = push_ready;
	assign push_valid = in_valid;
	assign accept = in_valid && push_ready;

	always_comb begin
		push_data.pix = in_data.pixel_index & mask;
		push_data.last = in_data.last_pixel;
		push_data.first = !started_q;
		push_data.bits = use_bits;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
			bits_q <= CFG_RESET;
			started_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (accept) begin
				started_q <= !in_data.last_pixel;
				if (!started_q) begin
					bits_q <= cfg_bits;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/gle_queue.sv =====
// Short request queue between front and back
`default_nettype none
module gle_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push_valid,
	output logic                            push_ready,
	input  wire gle_pkg::work_t             push_data,
	output logic                            pop_valid,
	input  wire logic                       pop_ready,
	output gle_pkg::work_t                  pop_data,
	output logic [$clog2(DEPTH+1)-1:0]      count
);
	import gle_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH+1);

	work_t          slot_q [DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;
	logic           push;
	logic           pop;

	assign push_ready = cnt_q != CW'(DEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_data = slot_q[rd_q];
	assign count = cnt_q;
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/gle_back.sv =====
// Back end: dictionary search and update, code sequencing
`default_nettype none
module gle_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              work_valid,
	output logic                   work_ready,
	input  wire gle_pkg::work_t    work,
	output logic                   code_valid,
	input  wire logic              code_ready,
	output gle_pkg::code_req_t     code
);
	import gle_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_CHILD = 9'b000000010,
		S_SIB   = 9'b000000100,
		S_LINK  = 9'b000001000,
		S_NEWE  = 9'b000010000,
		S_PFX   = 9'b000100000,
		S_CLR   = 9'b001000000,
		S_FP    = 9'b010000000,
		S_FE    = 9'b100000000
	} state_t;

	state_t            state_q;
	logic [7:0]        pix_q;
	logic              last_q;
	logic              first_q;
	logic [3:0]        bits_q;
	logic [ADDR_W-1:0] prefix_q;
	logic [ADDR_W-1:0] free_q;
	logic [3:0]        width_q;
	logic [ADDR_W-1:0] node_q;
	logic              link_child_q;
	logic [255:0]      root_valid_q;

	logic [ADDR_W-1:0] roots;
	logic [ADDR_W-1:0] new_roots;
	logic              is_root;
	logic [ADDR_W-1:0] child_rd;
	logic [ADDR_W-1:0] sib_rd;
	logic [SYM_W-1:0]  sym_rd;
	logic [ADDR_W-1:0] child_eff;
	logic              child_none;
	logic              sib_none;
	logic              grow;
	logic              code_go;

	logic              child_we;
	logic [ADDR_W-1:0] child_waddr;
	logic [ADDR_W-1:0] child_wdata;
	logic              sib_we;
	logic [ADDR_W-1:0] sib_waddr;
	logic [ADDR_W-1:0] sib_wdata;
	logic [ADDR_W-1:0] ss_raddr;

	assign roots = ADDR_W'(1) << bits_q;
	assign new_roots = ADDR_W'(1) << work.bits;
	assign is_root = node_q < roots;
	// a root's child field is stale until written in the current dictionary
	assign child_eff = (is_root && !root_valid_q[node_q[7:0]]) ? NO_ENTRY : child_rd;
	assign child_none = child_eff >= ENTRY_LIMIT;
	assign sib_none = sib_rd >= ENTRY_LIMIT;
	assign grow = (free_q >> width_q) != '0;

	assign work_ready = state_q == S_IDLE;
	assign code_valid = (state_q == S_PFX) || (state_q == S_CLR) ||
		(state_q == S_FP) || (state_q == S_FE);
	assign code_go = code_valid && code_ready;

	always_comb begin
		code.width = width_q;
		code.final_code = 1'b0;
		case (state_q)
			S_CLR: code.code = roots;
			S_FE: begin
				code.code = roots + ADDR_W'(1);
				code.final_code = 1'b1;
			end
			default: code.code = prefix_q;
		endcase
	end

	always_comb begin
		child_we = ((state_q == S_LINK) && link_child_q) || (state_q == S_NEWE);
		sib_we = ((state_q == S_LINK) && !link_child_q) || (state_q == S_NEWE);
		child_waddr = (state_q == S_LINK) ? node_q : free_q;
		child_wdata = (state_q == S_LINK) ? free_q : NO_ENTRY;
		sib_waddr = child_waddr;
		sib_wdata = child_wdata;
		ss_raddr = (state_q == S_CHILD) ? child_eff : sib_rd;
	end

	gle_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_ENTRIES)) u_child_ram (
		.clk   (clk),
		.we    (child_we),
		.waddr (child_waddr),
		.wdata (child_wdata),
		.raddr (prefix_q),
		.rdata (child_rd)
	);

	gle_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_ENTRIES)) u_sib_ram (
		.clk   (clk),
		.we    (sib_we),
		.waddr (sib_waddr),
		.wdata (sib_wdata),
		.raddr (ss_raddr),
		.rdata (sib_rd)
	);

	gle_ram #(.WIDTH(SYM_W), .DEPTH(TABLE_ENTRIES)) u_sym_ram (
		.clk   (clk),
		.we    (state_q == S_NEWE),
		.waddr (free_q),
		.wdata (pix_q),
		.raddr (ss_raddr),
		.rdata (sym_rd)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && work_valid) begin
			pix_q <= work.pix;
			last_q <= work.last;
			first_q <= work.first;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bits_q <= CFG_RESET;
			prefix_q <= '0;
			free_q <= ADDR_W'(258);
			width_q <= 4'd9;
			node_q <= '0;
			link_child_q <= 1'b0;
			root_valid_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (work_valid) begin
						if (work.first) begin
							bits_q <= work.bits;
							width_q <= work.bits + 4'd1;
							free_q <= new_roots + ADDR_W'(2);
							root_valid_q <= '0;
							state_q <= S_CLR;
						end else begin
							node_q <= prefix_q;
							state_q <= S_CHILD;
						end
					end
				end
				S_CHILD: begin
					if (child_none) begin
						link_child_q <= 1'b1;
						state_q <= S_LINK;
					end else begin
						node_q <= child_eff;
						state_q <= S_SIB;
					end
				end
				S_SIB: begin
					if (sym_rd == pix_q) begin
						prefix_q <= node_q;
						state_q <= last_q ? S_FP : S_IDLE;
					end else if (sib_none) begin
						link_child_q <= 1'b0;
						state_q <= S_LINK;
					end else begin
						node_q <= sib_rd;
					end
				end
				S_LINK: begin
					if (link_child_q && is_root) begin
						root_valid_q[node_q[7:0]] <= 1'b1;
					end
					state_q <= S_NEWE;
				end
				S_NEWE: state_q <= S_PFX;
				S_PFX: begin
					if (code_go) begin
						prefix_q <= ADDR_W'(pix_q);
						if (grow && width_q >= MAX_CODE_WIDTH && !last_q) begin
							state_q <= S_CLR;
						end else begin
							if (grow && width_q < MAX_CODE_WIDTH) begin
								width_q <= width_q + 4'd1;
							end
							if (free_q < LAST_ENTRY) begin
								free_q <= free_q + ADDR_W'(1);
							end
							state_q <= last_q ? S_FP : S_IDLE;
						end
					end
				end
				S_CLR: begin
					if (code_go) begin
						root_valid_q <= '0;
						free_q <= roots + ADDR_W'(2);
						width_q <= bits_q + 4'd1;
						if (first_q) begin
							prefix_q <= ADDR_W'(pix_q);
							state_q <= last_q ? S_FP : S_IDLE;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_FP: begin
					if (code_go) begin
						state_q <= S_FE;
					end
				end
				S_FE: begin
					if (code_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/gle_pack.sv =====
// Code packer: LSB-first bit packing, sub-block count, final flush
`default_nettype none
module gle_pack #(
	parameter int SUB_BLOCK_BYTES = 255
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               code_valid,
	output logic                    code_ready,
	input  wire gle_pkg::code_req_t code,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output gle_pkg::byte_out_t      out_data
);
	import gle_pkg::*;

	logic [23:0]       buf_q;
	logic [4:0]        cnt_q;
	logic              fin_q;
	logic [7:0]        blk_q;
	logic              ovalid_q;
	byte_out_t         out_q;

	logic [ADDR_W-1:0] masked;
	logic              emit;
	logic              slot_free;
	logic [7:0]        blk_nxt;
	logic              blk_end;
	logic              last_byte;

	assign code_ready = !fin_q && (cnt_q < 5'd8);
	assign masked = code.code & ((ADDR_W'(1) << code.width) - ADDR_W'(1));
	assign slot_free = !ovalid_q || out_ready;
	// during the flush a partial byte goes out zero padded
	assign emit = slot_free && ((cnt_q >= 5'd8) || (fin_q && cnt_q != '0));
	assign blk_nxt = blk_q + 8'd1;
	assign blk_end = blk_nxt >= 8'(SUB_BLOCK_BYTES);
	assign last_byte = fin_q && (cnt_q <= 5'd8);
	assign out_valid = ovalid_q;
	assign out_data = out_q;

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.code_byte <= buf_q[7:0];
			out_q.sub_block_end <= blk_end;
			out_q.stream_end <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q <= '0;
			cnt_q <= '0;
			fin_q <= 1'b0;
			blk_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (code_valid && code_ready) begin
				buf_q <= buf_q | (24'(masked) << cnt_q);
				cnt_q <= cnt_q + 5'(code.width);
				fin_q <= code.final_code;
			end else if (emit) begin
				if (last_byte) begin
					buf_q <= '0;
					cnt_q <= '0;
					fin_q <= 1'b0;
					blk_q <= '0;
				end else begin
					buf_q <= buf_q >> 8;
					cnt_q <= cnt_q - 5'd8;
					blk_q <= blk_end ? 8'd0 : blk_nxt;
				end
			end
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/gif_lzw_encoder_top.sv =====
// Per pixel, the back end reads the child of the prefix and then walks its siblings in the
// dictionary RAM; a match extends the prefix, else it links a new entry and emits a code.
// Its sibling walk sets the pace: a new pixel is taken only once the back end is idle.
// Bytes leave the packer one per cycle while out_ready holds, overlapping the next search.
// Reset clears control state and the root child flags; no memory clearing pass is needed.
`default_nettype none
module gif_lzw_encoder_top #(
	parameter int SUB_BLOCK_BYTES = 255,
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [3:0]         cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire gle_pkg::pix_in_t   in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output gle_pkg::byte_out_t      out_data
);
	import gle_pkg::*;
`include "gif_lzw_encoder_top_macros.svh"

	logic                             q_push_valid;
	logic                             q_push_ready;
	work_t                            q_push_data;
	logic                             q_pop_valid;
	logic                             q_pop_ready;
	work_t                            q_pop_data;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
	logic                             code_valid;
	logic                             code_ready;
	code_req_t                        code;

	gle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  (q_push_data)
	);

	gle_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_data  (q_push_data),
		.pop_valid  (q_pop_valid),
		.pop_ready  (q_pop_ready),
		.pop_data   (q_pop_data),
		.count      (q_count)
	);

	gle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.work_valid (q_pop_valid),
		.work_ready (q_pop_ready),
		.work       (q_pop_data),
		.code_valid (code_valid),
		.code_ready (code_ready),
		.code       (code)
	);

	gle_pack #(.SUB_BLOCK_BYTES(SUB_BLOCK_BYTES)) u_pack (
		.clk        (clk),
		.arst_n     (arst_n),
		.code_valid (code_valid),
		.code_ready (code_ready),
		.code       (code),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	`GLE_ASSERT_ALWAYS(a_code_width, !code_valid || (code.width >= 4'd2 && code.width <= MAX_CODE_WIDTH), "code width out of range")
	`GLE_ASSERT_NEXT(a_flush_locks, code_valid && code_ready && code.final_code, !code_ready, "packer took a code during flush")
	`GLE_ASSERT_NEXT(a_queue_fill, q_push_valid && q_push_ready && !(q_pop_valid && q_pop_ready), q_count == $past(q_count) + 1'b1, "queue count lost a push")
endmodule
`default_nettype wire
